// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker in rme_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
package rme_pkg;

  localparam int DATA_W       = 32;
  localparam int EXP_W        = 32;
  localparam int CHAR_W       = 8;
  localparam int MOD_BITS_DEF = 32;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_EXP = 2'd2;

  localparam logic [DATA_W-1:0] MODULUS_RST = 32'd2;
  localparam logic [DATA_W-1:0] ENC_EXP_RST = 32'd1;
  localparam logic [DATA_W-1:0] DEC_EXP_RST = 32'd1;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  // Per-cell control that rides along with the payload
  typedef struct packed {
    logic valid;
    op_e  op;
  } ctl_t;

endpackage

// File: rtl/core/rme_red_cell.sv
`timescale 1ns / 1ps
// One restoring-division step: shifts in the next value bit, subtracts n if it fits.
module rme_red_cell import rme_pkg::*; #(
  parameter int NW = MOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [NW-1:0]     n,
  input  ctl_t              ctl_in,
  input  logic [NW-1:0]     rem_in,
  input  logic [DATA_W-1:0] val_in,
  output ctl_t              ctl_out,
  output logic [NW-1:0]     rem_out,
  output logic [DATA_W-1:0] val_out
);

  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic [NW-1:0] rem_next;
  logic          valid;
  op_e           op;

  assign trial    = {rem_in, val_in[DATA_W-1]};
  assign diff     = trial - {1'b0, n};
  assign rem_next = (trial >= {1'b0, n}) ? diff[NW-1:0] : trial[NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op      <= ctl_in.op;
      rem_out <= rem_next;
      val_out <= {val_in[DATA_W-2:0], 1'b0};
    end
  end

  assign ctl_out = '{valid: valid, op: op};

endmodule

// File: rtl/core/rme_mul_cell.sv
`timescale 1ns / 1ps
// One MSB-first interleaved step of both products acc*sq and sq*sq mod n.
module rme_mul_cell import rme_pkg::*; #(
  parameter int NW  = MOD_BITS_DEF,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  ctl_t          ctl_in,
  input  logic [NW-1:0] acc_in,
  input  logic [NW-1:0] sq_in,
  input  logic [NW-1:0] pa_in,
  input  logic [NW-1:0] ps_in,
  output ctl_t          ctl_out,
  output logic [NW-1:0] acc_out,
  output logic [NW-1:0] sq_out,
  output logic [NW-1:0] pa_out,
  output logic [NW-1:0] ps_out
);

  // r < n and a < n, so 2r + a < 3n: at most one of n or 2n comes off
  function automatic logic [NW-1:0] mod_step(input logic [NW-1:0] r,
                                             input logic [NW-1:0] a,
                                             input logic [NW-1:0] m,
                                             input logic          b);
    logic [NW+1:0] t;
    logic [NW+1:0] m1;
    logic [NW+1:0] m2;
    t  = {1'b0, r, 1'b0} + {2'b00, a & {NW{b}}};
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end
    return t[NW-1:0];
  endfunction

  logic valid;
  op_e  op;
  logic b;

  assign b = sq_in[BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op      <= ctl_in.op;
      acc_out <= acc_in;
      sq_out  <= sq_in;
      pa_out  <= mod_step(pa_in, acc_in, n, b);
      ps_out  <= mod_step(ps_in, sq_in, n, b);
    end
  end

  assign ctl_out = '{valid: valid, op: op};

endmodule

// File: rtl/core/rme_exp_stage.sv
`timescale 1ns / 1ps
// One exponent bit: a row of NW multiply cells, then keep or take the product.
module rme_exp_stage import rme_pkg::*; #(
  parameter int NW = MOD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic          enc_bit,
  input  logic          dec_bit,
  input  ctl_t          ctl_in,
  input  logic [NW-1:0] acc_in,
  input  logic [NW-1:0] sq_in,
  output ctl_t          ctl_out,
  output logic [NW-1:0] acc_out,
  output logic [NW-1:0] sq_out
);

  ctl_t          c  [NW+1];
  logic [NW-1:0] a  [NW+1];
  logic [NW-1:0] s  [NW+1];
  logic [NW-1:0] pa [NW+1];
  logic [NW-1:0] ps [NW+1];
  logic          use_mul;

  assign c[0]  = ctl_in;
  assign a[0]  = acc_in;
  assign s[0]  = sq_in;
  assign pa[0] = '0;
  assign ps[0] = '0;

  for (genvar j = 0; j < NW; j++) begin : g_cell
    rme_mul_cell #(.NW(NW), .BIT(NW-1-j)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .n       (n),
      .ctl_in  (c[j]),
      .acc_in  (a[j]),
      .sq_in   (s[j]),
      .pa_in   (pa[j]),
      .ps_in   (ps[j]),
      .ctl_out (c[j+1]),
      .acc_out (a[j+1]),
      .sq_out  (s[j+1]),
      .pa_out  (pa[j+1]),
      .ps_out  (ps[j+1])
    );
  end

  assign use_mul = (c[NW].op == OP_DECRYPT) ? dec_bit : enc_bit;
  assign ctl_out = c[NW];
  assign acc_out = use_mul ? pa[NW] : a[NW];
  assign sq_out  = ps[NW];

endmodule

// File: rtl/core/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                          Contents (low bit first)
// s_*       in   s_tvalid s_tready s_tuser s_tdata tuser: operation; tdata: value
// m_*       out  m_tvalid m_tready m_tdata         tdata: result
// cfg_*     in   cfg_we cfg_idx cfg_data          0 modulus, 1 enc exp, 2 dec exp
//
// Accepts one item per clock while s_tready is high; NW = min(MOD_BITS, 32).
// 32 division cells reduce the value, then 32 exponent rows of NW multiply cells each.
// Reset clears all valid bits and the output buffer; config regs return to n=2, e=d=1.
// The whole chain holds only when the two-entry output buffer is full and a valid item
// waits at the tail; m_tready does not reach s_tready in the same cycle.
module rsa_modular_exponentiation import rme_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tuser,    // [0] operation
  input  logic [DATA_W-1:0]    s_tdata,    // [31:0] value
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,    // [31:0] result
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int NW = (MOD_BITS < DATA_W) ? MOD_BITS : DATA_W;

  logic [DATA_W-1:0] modulus;
  logic [DATA_W-1:0] enc_exp;
  logic [DATA_W-1:0] dec_exp;
  logic [NW-1:0]     n;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
      enc_exp <= ENC_EXP_RST;
      dec_exp <= DEC_EXP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODULUS: modulus <= cfg_data;
        REG_ENC_EXP: enc_exp <= cfg_data;
        REG_DEC_EXP: dec_exp <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n = modulus[NW-1:0];

  // global advance: chain moves unless the output buffer would overflow
  logic en;

  // value mod n, one quotient bit per cell
  ctl_t              rc   [DATA_W+1];
  logic [NW-1:0]     rrem [DATA_W+1];
  logic [DATA_W-1:0] rval [DATA_W+1];

  assign rc[0]   = '{valid: s_tvalid, op: op_e'(s_tuser)};
  assign rrem[0] = '0;
  assign rval[0] = s_tdata;

  for (genvar i = 0; i < DATA_W; i++) begin : g_red
    rme_red_cell #(.NW(NW)) u_red (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .n       (n),
      .ctl_in  (rc[i]),
      .rem_in  (rrem[i]),
      .val_in  (rval[i]),
      .ctl_out (rc[i+1]),
      .rem_out (rrem[i+1]),
      .val_out (rval[i+1])
    );
  end

  // square-and-multiply, exponent LSB first
  ctl_t          ec [EXP_W+1];
  logic [NW-1:0] ea [EXP_W+1];
  logic [NW-1:0] es [EXP_W+1];

  assign ec[0] = rc[DATA_W];
  assign ea[0] = (n == NW'(1)) ? '0 : NW'(1);   // 1 mod n
  assign es[0] = rrem[DATA_W];

  for (genvar k = 0; k < EXP_W; k++) begin : g_exp
    rme_exp_stage #(.NW(NW)) u_exp (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .n       (n),
      .enc_bit (enc_exp[k]),
      .dec_bit (dec_exp[k]),
      .ctl_in  (ec[k]),
      .acc_in  (ea[k]),
      .sq_in   (es[k]),
      .ctl_out (ec[k+1]),
      .acc_out (ea[k+1]),
      .sq_out  (es[k+1])
    );
  end

  // final formatting: zero modulus gives 0, decrypt keeps the low byte
  ctl_t              tail;
  logic [DATA_W-1:0] res;

  assign tail = ec[EXP_W];

  always_comb begin
    if (n == '0) begin
      res = '0;
    end else if (tail.op == OP_DECRYPT) begin
      res = DATA_W'(ea[EXP_W][CHAR_W-1:0]);
    end else begin
      res = DATA_W'(ea[EXP_W]);
    end
  end

  // two-entry output buffer
  logic [DATA_W-1:0] obuf [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;

  // built from registers only, so m_tready never feeds the chain enable
  assign en       = (cnt != 2'd2) | ~tail.valid;
  assign push     = tail.valid & en;
  assign pop      = m_tvalid & m_tready;
  assign s_tready = en;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = obuf[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wptr] <= res;
    end
  end

endmodule

// File: rtl/core/rme_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rme_checker import rme_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tuser,
  input logic [DATA_W-1:0] s_tdata,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  // items in flight, seen from the ports
  logic [11:0] pending;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = s_tvalid & s_tready;
  assign out_acc = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {11'd0, in_acc} - {11'd0, out_acc};
    end
  end

  `AST_NOW(a_no_phantom, clk, rst, m_tvalid, pending != 12'd0, "result with no item in flight")
  `AST_NOW(a_stall_cause, clk, rst, !s_tready, m_tvalid, "input stalled with output empty")
  `AST_NOW(a_clean_reset, clk, rst, $past(rst), !m_tvalid, "output valid right after reset")
  `AST_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
            "stalled result changed")

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (.*);
